// ===== rtl/fsgs_pkg.sv =====
// fsgs_pkg: grid geometry, cell layout, action codes and shared structs
// for the falling sand grid step block
// no dependencies
`default_nettype none

package fsgs_pkg;

    localparam int GRID_ROWS  = 32;
    localparam int GRID_COLS  = 32;
    localparam int CELL_COUNT = GRID_ROWS * GRID_COLS;
    localparam int ADDR_W     = $clog2(CELL_COUNT);
    localparam int ROW_W      = $clog2(GRID_ROWS);
    localparam int COL_W      = $clog2(GRID_COLS);

    localparam int ACTION_W = 2;
    localparam int COORD_W  = 5;
    localparam int COLOR_W  = 6;
    localparam int SEED_W   = 16;
    localparam int CELL_W   = 8;

    localparam logic [CELL_W-1:0] MARK_MOVED  = 8'h80;
    localparam logic [CELL_W-1:0] MARK_ACTIVE = 8'h40;
    localparam int                ACTIVE_BIT  = 6;
    localparam logic [SEED_W-1:0] LFSR_TAPS   = 16'hB400;
    localparam logic [SEED_W-1:0] SEED_RESET  = 16'h0001;

    typedef enum logic [ACTION_W-1:0] {
        ACT_WRITE = 2'd0,
        ACT_FILL  = 2'd1,
        ACT_READ  = 2'd2,
        ACT_STEP  = 2'd3
    } action_t;

    typedef struct packed {
        action_t              action;
        logic [COORD_W-1:0]   cell_row;
        logic [COORD_W-1:0]   cell_col;
        logic [COLOR_W-1:0]   paint_color;
    } cmd_t;

    typedef struct packed {
        logic [COLOR_W-1:0] read_color;
        logic               read_active;
    } res_t;

    function automatic logic on_grid(input logic [COORD_W-1:0] row,
                                     input logic [COORD_W-1:0] col);
        return (int'(row) < GRID_ROWS) && (int'(col) < GRID_COLS);
    endfunction

    function automatic logic [ADDR_W-1:0] cell_index(input logic [COORD_W-1:0] row,
                                                      input logic [COORD_W-1:0] col);
        return ADDR_W'(int'(row) * GRID_COLS + int'(col));
    endfunction

endpackage

`default_nettype wire

// ===== rtl/fsgs_if.sv =====
// fsgs channel interfaces: command, response and seed configuration words
// depends on fsgs_pkg
`default_nettype none

interface fsgs_cmd_if;
    logic                          valid;
    logic                          ready;
    fsgs_pkg::action_t             action;
    logic [fsgs_pkg::COORD_W-1:0]  cell_row;
    logic [fsgs_pkg::COORD_W-1:0]  cell_col;
    logic [fsgs_pkg::COLOR_W-1:0]  paint_color;

    modport source (output valid, action, cell_row, cell_col, paint_color, input ready);
    modport sink   (input valid, action, cell_row, cell_col, paint_color, output ready);
endinterface

interface fsgs_rsp_if;
    logic                          valid;
    logic                          ready;
    logic [fsgs_pkg::COLOR_W-1:0]  read_color;
    logic                          read_active;

    modport source (output valid, read_color, read_active, input ready);
    modport sink   (input valid, read_color, read_active, output ready);
endinterface

interface fsgs_cfg_if;
    logic                          valid;
    logic                          ready;
    logic [fsgs_pkg::SEED_W-1:0]   random_seed;

    modport source (output valid, random_seed, input ready);
    modport sink   (input valid, random_seed, output ready);
endinterface

`default_nettype wire

// ===== rtl/falling_sand_grid_step.sv =====
// falling_sand_grid_step: top level, channel handshakes, output word register
// depends on fsgs_pkg, fsgs_if, fsgs_lfsr, fsgs_engine
//
//  port  | dir | word
//  ------+-----+--------------------------------------------------
//  cmd   | in  | action, cell_row, cell_col, paint_color
//  rsp   | out | read_color, read_active
//  cfg   | in  | random_seed (also reloads the direction lfsr)
//
// a generation sweeps the (GRID_ROWS - 1) * GRID_COLS cells above the bottom row; in each cell
// the sequencer skips, finds a blocked grain, lets a grain fall or tries a diagonal
// after reset a clearing pass over all CELL_COUNT cells runs before cmd is ready
// cmd is taken only while the sequencer is idle; a held rsp word stalls the next finish
`default_nettype none

module falling_sand_grid_step (
    input  wire logic  clk,
    input  wire logic  rst_n,
    fsgs_cmd_if.sink   cmd,
    fsgs_rsp_if.source rsp,
    fsgs_cfg_if.sink   cfg
);

    fsgs_pkg::cmd_t cmd_word;
    fsgs_pkg::res_t eng_res;
    fsgs_pkg::res_t rsp_word_reg, rsp_word_next;
    logic           rsp_valid_reg, rsp_valid_next;
    logic           eng_idle;
    logic           eng_res_valid;
    logic           eng_res_ready;
    logic           lfsr_step;
    logic           lfsr_bit;

    assign cmd_word.action      = cmd.action;
    assign cmd_word.cell_row    = cmd.cell_row;
    assign cmd_word.cell_col    = cmd.cell_col;
    assign cmd_word.paint_color = cmd.paint_color;

    assign cmd.ready = eng_idle;
    assign cfg.ready = 1'b1;

    fsgs_lfsr u_lfsr (
        .clk       (clk),
        .rst_n     (rst_n),
        .seed_load (cfg.valid),
        .seed      (cfg.random_seed),
        .step      (lfsr_step),
        .dir_bit   (lfsr_bit)
    );

    fsgs_engine u_engine (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd.valid),
        .cmd       (cmd_word),
        .idle      (eng_idle),
        .res_valid (eng_res_valid),
        .res_ready (eng_res_ready),
        .res       (eng_res),
        .lfsr_step (lfsr_step),
        .lfsr_bit  (lfsr_bit)
    );

    assign eng_res_ready = !rsp_valid_reg || rsp.ready;

    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        rsp_word_next  = rsp_word_reg;
        if (eng_res_valid && eng_res_ready)
        begin
            rsp_valid_next = 1'b1;
            rsp_word_next  = eng_res;
        end
        else if (rsp.ready)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rsp_word_reg <= rsp_word_next;
    end

    assign rsp.valid       = rsp_valid_reg;
    assign rsp.read_color  = rsp_word_reg.read_color;
    assign rsp.read_active = rsp_word_reg.read_active;

endmodule

`default_nettype wire

// ===== rtl/fsgs_lfsr.sv =====
// fsgs_lfsr: 16-bit galois lfsr that picks the diagonal direction
// depends on fsgs_pkg
`default_nettype none

module fsgs_lfsr (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        seed_load,
    input  wire logic [fsgs_pkg::SEED_W-1:0] seed,
    input  wire logic                        step,
    output logic                             dir_bit
);

    logic [fsgs_pkg::SEED_W-1:0] lfsr_reg;
    logic [fsgs_pkg::SEED_W-1:0] lfsr_next;

    always_comb
    begin
        lfsr_next = lfsr_reg;
        if (seed_load)
        begin
            // zero seed would lock up
            lfsr_next = (seed == '0) ? fsgs_pkg::SEED_RESET : seed;
        end
        else if (step)
        begin
            lfsr_next = (lfsr_reg >> 1) ^ (lfsr_reg[0] ? fsgs_pkg::LFSR_TAPS : '0);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lfsr_reg <= fsgs_pkg::SEED_RESET;
        end
        else
        begin
            lfsr_reg <= lfsr_next;
        end
    end

    assign dir_bit = lfsr_reg[0];

endmodule

`default_nettype wire

// ===== rtl/fsgs_engine.sv =====
// fsgs_engine: grid memory and the sequencer that reads, modifies and writes
// cells for write, fill, read and generation actions, plus the reset clear
// depends on fsgs_pkg
`default_nettype none

module fsgs_engine (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           cmd_valid,
    input  wire fsgs_pkg::cmd_t cmd,
    output logic                idle,
    output logic                res_valid,
    input  wire logic           res_ready,
    output fsgs_pkg::res_t      res,
    output logic                lfsr_step,
    input  wire logic           lfsr_bit
);

    typedef enum logic [8:0] {
        S_CLEAR  = 9'b000000001,
        S_IDLE   = 9'b000000010,
        S_FILL   = 9'b000000100,
        S_READ   = 9'b000001000,
        S_G_CUR  = 9'b000010000,
        S_G_DOWN = 9'b000100000,
        S_G_DIAG = 9'b001000000,
        S_G_CLR  = 9'b010000000,
        S_RESP   = 9'b100000000
    } state_t;

    localparam int ADDR_W  = fsgs_pkg::ADDR_W;
    localparam int CELL_W  = fsgs_pkg::CELL_W;
    localparam int COLOR_W = fsgs_pkg::COLOR_W;

    logic [CELL_W-1:0] grid_mem [fsgs_pkg::CELL_COUNT];
    logic [CELL_W-1:0] mem_rdata_reg;
    logic              mem_we;
    logic [ADDR_W-1:0] mem_waddr;
    logic [CELL_W-1:0] mem_wdata;
    logic              mem_re;
    logic [ADDR_W-1:0] mem_raddr;

    state_t                     state_reg, state_next;
    logic [ADDR_W-1:0]          addr_reg, addr_next;
    logic [fsgs_pkg::ROW_W-1:0] row_reg, row_next;
    logic [fsgs_pkg::COL_W-1:0] col_reg, col_next;
    logic [CELL_W-1:0]          cur_reg, cur_next;
    logic [ADDR_W-1:0]          dest_reg, dest_next;
    logic [COLOR_W-1:0]         color_reg, color_next;
    fsgs_pkg::res_t             res_reg, res_next;

    logic              advance;
    logic              gen_last;
    logic              col_last;
    logic              sweep_last;
    logic              cmd_take;
    logic              diag_ok;
    logic [ADDR_W-1:0] down_addr;
    logic [ADDR_W-1:0] diag_addr;

    assign col_last   = (col_reg == fsgs_pkg::COL_W'(fsgs_pkg::GRID_COLS - 1));
    assign gen_last   = col_last && (row_reg == fsgs_pkg::ROW_W'(fsgs_pkg::GRID_ROWS - 2));
    assign sweep_last = (addr_reg == ADDR_W'(fsgs_pkg::CELL_COUNT - 1));
    assign down_addr  = addr_reg + ADDR_W'(fsgs_pkg::GRID_COLS);
    assign diag_addr  = lfsr_bit ? down_addr + ADDR_W'(1) : down_addr - ADDR_W'(1);
    assign diag_ok    = lfsr_bit ? !col_last : (col_reg != '0);
    assign cmd_take   = cmd_valid && (state_reg == S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        addr_next  = addr_reg;
        row_next   = row_reg;
        col_next   = col_reg;
        cur_next   = cur_reg;
        dest_next  = dest_reg;
        color_next = color_reg;
        res_next   = res_reg;
        mem_we     = 1'b0;
        mem_waddr  = addr_reg;
        mem_wdata  = '0;
        mem_re     = 1'b0;
        mem_raddr  = addr_reg;
        lfsr_step  = 1'b0;
        advance    = 1'b0;

        unique case (state_reg)
            S_CLEAR:
            begin
                mem_we    = 1'b1;
                addr_next = addr_reg + ADDR_W'(1);
                if (sweep_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (cmd_take)
                begin
                    res_next = '0;
                    case (cmd.action)
                        fsgs_pkg::ACT_WRITE:
                        begin
                            mem_we     = fsgs_pkg::on_grid(cmd.cell_row, cmd.cell_col);
                            mem_waddr  = fsgs_pkg::cell_index(cmd.cell_row, cmd.cell_col);
                            mem_wdata  = CELL_W'(cmd.paint_color);
                            state_next = S_RESP;
                        end
                        fsgs_pkg::ACT_FILL:
                        begin
                            color_next = cmd.paint_color;
                            addr_next  = '0;
                            state_next = S_FILL;
                        end
                        fsgs_pkg::ACT_READ:
                        begin
                            if (fsgs_pkg::on_grid(cmd.cell_row, cmd.cell_col))
                            begin
                                mem_re     = 1'b1;
                                mem_raddr  = fsgs_pkg::cell_index(cmd.cell_row, cmd.cell_col);
                                state_next = S_READ;
                            end
                            else
                            begin
                                state_next = S_RESP;
                            end
                        end
                        default:
                        begin
                            mem_re     = 1'b1;
                            mem_raddr  = '0;
                            addr_next  = '0;
                            row_next   = '0;
                            col_next   = '0;
                            state_next = S_G_CUR;
                        end
                    endcase
                end
            end
            S_FILL:
            begin
                mem_we    = 1'b1;
                mem_wdata = CELL_W'(color_reg);
                addr_next = addr_reg + ADDR_W'(1);
                if (sweep_last)
                begin
                    state_next = S_RESP;
                end
            end
            S_READ:
            begin
                res_next.read_color  = mem_rdata_reg[COLOR_W-1:0];
                res_next.read_active = mem_rdata_reg[fsgs_pkg::ACTIVE_BIT];
                state_next           = S_RESP;
            end
            S_G_CUR:
            begin
                cur_next = mem_rdata_reg;
                if ((mem_rdata_reg & fsgs_pkg::MARK_MOVED) != '0)
                begin
                    // moved in from above this pass: drop the mark and skip
                    mem_we    = 1'b1;
                    mem_wdata = mem_rdata_reg & ~fsgs_pkg::MARK_MOVED;
                    advance   = 1'b1;
                end
                else if (mem_rdata_reg[COLOR_W-1:0] == '0)
                begin
                    advance = 1'b1;
                end
                else
                begin
                    mem_re     = 1'b1;
                    mem_raddr  = down_addr;
                    state_next = S_G_DOWN;
                end
            end
            S_G_DOWN:
            begin
                if (mem_rdata_reg[COLOR_W-1:0] == '0)
                begin
                    mem_we     = 1'b1;
                    mem_waddr  = down_addr;
                    mem_wdata  = cur_reg | fsgs_pkg::MARK_MOVED | fsgs_pkg::MARK_ACTIVE;
                    state_next = S_G_CLR;
                end
                else if ((cur_reg & fsgs_pkg::MARK_ACTIVE) != '0)
                begin
                    lfsr_step = 1'b1;
                    if (diag_ok)
                    begin
                        mem_re     = 1'b1;
                        mem_raddr  = diag_addr;
                        dest_next  = diag_addr;
                        state_next = S_G_DIAG;
                    end
                    else
                    begin
                        mem_we    = 1'b1;
                        mem_wdata = cur_reg & ~fsgs_pkg::MARK_ACTIVE;
                        advance   = 1'b1;
                    end
                end
                else
                begin
                    advance = 1'b1;
                end
            end
            S_G_DIAG:
            begin
                if (mem_rdata_reg[COLOR_W-1:0] == '0)
                begin
                    mem_we     = 1'b1;
                    mem_waddr  = dest_reg;
                    mem_wdata  = cur_reg | fsgs_pkg::MARK_MOVED;
                    state_next = S_G_CLR;
                end
                else
                begin
                    mem_we    = 1'b1;
                    mem_wdata = cur_reg & ~fsgs_pkg::MARK_ACTIVE;
                    advance   = 1'b1;
                end
            end
            S_G_CLR:
            begin
                mem_we  = 1'b1;
                advance = 1'b1;
            end
            S_RESP:
            begin
                if (res_ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (advance)
        begin
            if (gen_last)
            begin
                state_next = S_RESP;
            end
            else
            begin
                // start the read of the next cell right away
                mem_re     = 1'b1;
                mem_raddr  = addr_reg + ADDR_W'(1);
                addr_next  = addr_reg + ADDR_W'(1);
                state_next = S_G_CUR;
                if (col_last)
                begin
                    col_next = '0;
                    row_next = row_reg + fsgs_pkg::ROW_W'(1);
                end
                else
                begin
                    col_next = col_reg + fsgs_pkg::COL_W'(1);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            addr_reg  <= '0;
            row_reg   <= '0;
            col_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            addr_reg  <= addr_next;
            row_reg   <= row_next;
            col_reg   <= col_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg   <= cur_next;
        dest_reg  <= dest_next;
        color_reg <= color_next;
        res_reg   <= res_next;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            grid_mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            mem_rdata_reg <= grid_mem[mem_raddr];
        end
    end

    assign idle      = (state_reg == S_IDLE);
    assign res_valid = (state_reg == S_RESP);
    assign res       = res_reg;

endmodule

`default_nettype wire

// ===== tb/sv/tb.sv =====
// tb: self-checking bench for falling_sand_grid_step; a scoreboard class keeps its own
// grid and direction lfsr; tasks drive commands and seeds, a response block checks words
// depends on fsgs_pkg, the fsgs channel interfaces and the falling_sand_grid_step rtl
import fsgs_pkg::*;

class grid_scoreboard;
    logic [CELL_W-1:0] cells [CELL_COUNT];
    logic [SEED_W-1:0] lfsr;
    res_t              expected_q [$];
    int                errors;
    int                words_noted;
    int                generations;
    int                draws;
    int                seed_loads;

    function new();
        foreach (cells[i]) cells[i] = '0;
        lfsr        = SEED_RESET;
        errors      = 0;
        words_noted = 0;
        generations = 0;
        draws       = 0;
        seed_loads  = 0;
    endfunction

    function void load_seed(logic [SEED_W-1:0] seed);
        // a zero seed would lock the lfsr
        lfsr = (seed == '0) ? 16'h0001 : seed;
        seed_loads++;
    endfunction

    function bit pick_right();
        bit low;
        low  = lfsr[0];
        lfsr = (lfsr >> 1) ^ (low ? LFSR_TAPS : '0);
        draws++;
        return low;
    endfunction

    function bit is_empty(logic [CELL_W-1:0] v);
        return v[COLOR_W-1:0] == '0;
    endfunction

    function void settle_generation();
        int                r;
        int                c;
        int                here;
        int                below;
        int                dest;
        bit                ok;
        logic [CELL_W-1:0] cur;
        for (r = 0; r < GRID_ROWS - 1; r++) begin
            for (c = 0; c < GRID_COLS; c++) begin
                here  = r * GRID_COLS + c;
                below = here + GRID_COLS;
                cur   = cells[here];
                if ((cur & MARK_MOVED) == '0 && !is_empty(cur)) begin
                    if (is_empty(cells[below])) begin
                        cells[below] = cur | MARK_MOVED | MARK_ACTIVE;
                        cells[here]  = MARK_MOVED;
                    end
                    else if ((cur & MARK_ACTIVE) != '0) begin
                        if (pick_right()) begin
                            ok   = (c + 1 < GRID_COLS);
                            dest = below + 1;
                        end
                        else begin
                            ok   = (c > 0);
                            dest = below - 1;
                        end
                        if (ok && is_empty(cells[dest])) begin
                            cells[dest] = cur | MARK_MOVED;
                            cells[here] = MARK_MOVED;
                        end
                        else begin
                            cells[here] = (cur & ~MARK_ACTIVE) | MARK_MOVED;
                        end
                    end
                    else begin
                        cells[here] = cur | MARK_MOVED;
                    end
                end
            end
        end
        foreach (cells[i]) cells[i] = cells[i] & ~MARK_MOVED;
        generations++;
    endfunction

    function void note_cmd(action_t act, logic [COORD_W-1:0] row, logic [COORD_W-1:0] col,
                           logic [COLOR_W-1:0] color);
        res_t w;
        int   idx;
        bit   inside_grid;
        w           = '0;
        idx         = int'(row) * GRID_COLS + int'(col);
        inside_grid = (int'(row) < GRID_ROWS) && (int'(col) < GRID_COLS);
        case (act)
            ACT_WRITE: if (inside_grid) cells[idx] = CELL_W'(color);
            ACT_FILL:  foreach (cells[i]) cells[i] = CELL_W'(color);
            ACT_READ:
                if (inside_grid) begin
                    w.read_color  = cells[idx][COLOR_W-1:0];
                    w.read_active = cells[idx][ACTIVE_BIT];
                end
            default:   settle_generation();
        endcase
        expected_q.push_back(w);
        words_noted++;
    endfunction

    function void check_word(logic [COLOR_W-1:0] color, logic active);
        res_t w;
        if (expected_q.size() == 0) begin
            $error("unexpected response word: read_color %0d read_active %0d", color, active);
            errors++;
            return;
        end
        w = expected_q.pop_front();
        if (color !== w.read_color) begin
            $error("read_color mismatch: expected %0d, actual %0d", w.read_color, color);
            errors++;
        end
        if (active !== w.read_active) begin
            $error("read_active mismatch: expected %0d, actual %0d", w.read_active, active);
            errors++;
        end
    endfunction
endclass

module tb;
    logic           clk;
    logic           rst_n;
    bit             idle_on;
    int             sent;
    grid_scoreboard sb;

    fsgs_cmd_if cmd_ch ();
    fsgs_rsp_if rsp_ch ();
    fsgs_cfg_if cfg_ch ();

    falling_sand_grid_step uut (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd_ch),
        .rsp   (rsp_ch),
        .cfg   (cfg_ch)
    );

    always
    begin
        clk = 1'b0;
        #2;
        clk = 1'b1;
        #2;
    end

    task automatic send_cmd(action_t act, logic [COORD_W-1:0] row, logic [COORD_W-1:0] col,
                            logic [COLOR_W-1:0] color);
        int gap;
        gap = idle_on ? $urandom_range(0, 15) : 0;
        if (gap != 0)
        begin
            cmd_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        cmd_ch.valid       <= 1'b1;
        cmd_ch.action      <= act;
        cmd_ch.cell_row    <= row;
        cmd_ch.cell_col    <= col;
        cmd_ch.paint_color <= color;
        @(negedge clk);
        while (cmd_ch.ready !== 1'b1) @(negedge clk);
        sb.note_cmd(act, row, col, color);
        sent++;
        @(posedge clk);
    endtask

    task automatic drain();
        cmd_ch.valid <= 1'b0;
        while (sb.expected_q.size() != 0) @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic write_seed(logic [SEED_W-1:0] seed);
        cfg_ch.valid       <= 1'b1;
        cfg_ch.random_seed <= seed;
        @(negedge clk);
        while (cfg_ch.ready !== 1'b1) @(negedge clk);
        sb.load_seed(seed);
        @(posedge clk);
        cfg_ch.valid <= 1'b0;
    endtask

    task automatic read_near(logic [COORD_W-1:0] left_col);
        send_cmd(ACT_READ, COORD_W'($urandom_range(24, 31)),
                 left_col + COORD_W'($urandom_range(0, 5)), COLOR_W'($urandom_range(0, 63)));
    endtask

    task automatic run_scene();
        logic [COLOR_W-1:0] base;
        logic [COLOR_W-1:0] color;
        logic [COORD_W-1:0] left_col;
        logic [COORD_W-1:0] row;
        int                 n;
        int                 k;
        int                 j;
        idle_on = ($urandom_range(0, 3) != 0);
        base    = ($urandom_range(0, 3) == 0) ? COLOR_W'($urandom_range(1, 63)) : '0;
        case ($urandom_range(0, 3))
            0:       left_col = '0;
            1:       left_col = COORD_W'(GRID_COLS - 6);
            default: left_col = COORD_W'($urandom_range(0, GRID_COLS - 6));
        endcase
        send_cmd(ACT_FILL, COORD_W'($urandom), COORD_W'($urandom), base);
        // grains on an empty grid, or holes punched into a full one
        n = $urandom_range(2, 8);
        for (k = 0; k < n; k++)
        begin
            if (base == '0)
            begin
                row   = COORD_W'($urandom_range(20, 31));
                color = ($urandom_range(0, 7) == 0) ? '0 : COLOR_W'($urandom_range(1, 63));
            end
            else
            begin
                row   = COORD_W'($urandom_range(24, 31));
                color = ($urandom_range(0, 1) == 0) ? '0 : COLOR_W'($urandom_range(1, 63));
            end
            send_cmd(ACT_WRITE, row, left_col + COORD_W'($urandom_range(0, 5)), color);
        end
        if ($urandom_range(0, 3) == 0)
            drain();
        n = $urandom_range(1, 5);
        for (k = 0; k < n; k++)
        begin
            send_cmd(ACT_STEP, COORD_W'($urandom), COORD_W'($urandom), COLOR_W'($urandom));
            for (j = $urandom_range(0, 2); j > 0; j--)
                read_near(left_col);
        end
        for (j = $urandom_range(2, 5); j > 0; j--)
            read_near(left_col);
        // noise words with any action and any fields
        if ($urandom_range(0, 2) == 0)
            for (j = $urandom_range(1, 3); j > 0; j--)
                send_cmd(action_t'($urandom_range(0, 3)), COORD_W'($urandom),
                         COORD_W'($urandom), COLOR_W'($urandom));
    endtask

    task automatic directed_items();
        send_cmd(ACT_READ,  5'd0,  5'd0,  6'd0);
        send_cmd(ACT_WRITE, 5'd0,  5'd0,  6'd63);
        send_cmd(ACT_WRITE, 5'd31, 5'd31, 6'd1);
        send_cmd(ACT_READ,  5'd0,  5'd0,  6'd0);
        send_cmd(ACT_STEP,  5'd0,  5'd0,  6'd0);
        send_cmd(ACT_READ,  5'd1,  5'd0,  6'd0);
        send_cmd(ACT_FILL,  5'd31, 5'd31, 6'd63);
        send_cmd(ACT_STEP,  5'd0,  5'd0,  6'd63);
        send_cmd(ACT_WRITE, 5'd31, 5'd0,  6'd0);
        send_cmd(ACT_STEP,  5'd0,  5'd0,  6'd0);
        send_cmd(ACT_READ,  5'd31, 5'd0,  6'd0);
        send_cmd(ACT_READ,  5'd30, 5'd0,  6'd0);
        // blocked grains at both grid edges, diagonals partly off the grid
        send_cmd(ACT_FILL,  5'd0,  5'd0,  6'd0);
        send_cmd(ACT_WRITE, 5'd28, 5'd0,  6'd7);
        send_cmd(ACT_WRITE, 5'd30, 5'd0,  6'd5);
        send_cmd(ACT_WRITE, 5'd31, 5'd0,  6'd6);
        send_cmd(ACT_WRITE, 5'd28, 5'd31, 6'd9);
        send_cmd(ACT_WRITE, 5'd30, 5'd31, 6'd10);
        send_cmd(ACT_WRITE, 5'd31, 5'd31, 6'd11);
        send_cmd(ACT_STEP,  5'd0,  5'd0,  6'd0);
        send_cmd(ACT_STEP,  5'd0,  5'd0,  6'd0);
        send_cmd(ACT_READ,  5'd29, 5'd0,  6'd0);
        send_cmd(ACT_READ,  5'd30, 5'd1,  6'd0);
        send_cmd(ACT_READ,  5'd29, 5'd31, 6'd0);
        send_cmd(ACT_READ,  5'd30, 5'd30, 6'd0);
    endtask

    initial
    begin : response_side
        int stall;
        rsp_ch.ready <= 1'b0;
        @(posedge clk);
        forever
        begin
            stall = idle_on ? $urandom_range(0, 15) : 0;
            if (stall != 0)
            begin
                rsp_ch.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            rsp_ch.ready <= 1'b1;
            @(negedge clk);
            while (rsp_ch.valid !== 1'b1) @(negedge clk);
            sb.check_word(rsp_ch.read_color, rsp_ch.read_active);
            @(posedge clk);
        end
    end

    initial
    begin : stimulus
        logic [SEED_W-1:0] seeds [5];
        int                phase;
        int                target;
        sb                  = new();
        sent                = 0;
        idle_on             = 1'b1;
        rst_n              <= 1'b0;
        cmd_ch.valid       <= 1'b0;
        cmd_ch.action      <= ACT_WRITE;
        cmd_ch.cell_row    <= '0;
        cmd_ch.cell_col    <= '0;
        cmd_ch.paint_color <= '0;
        cfg_ch.valid       <= 1'b0;
        cfg_ch.random_seed <= '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        directed_items();
        seeds = '{16'h0000, 16'hFFFF, 16'h0001,
                  SEED_W'($urandom_range(1, 65535)), SEED_W'($urandom_range(1, 65535))};
        target = sent;
        for (phase = 0; phase < 5; phase++)
        begin
            drain();
            write_seed(seeds[phase]);
            target += 32;
            while (sent < target)
                run_scene();
        end
        drain();
        repeat (16) @(posedge clk);
        if (sb.expected_q.size() != 0)
        begin
            $error("%0d expected response words never arrived", sb.expected_q.size());
            sb.errors++;
        end
        $display("covered %0d command words under %0d seed loads, zero and all-ones among them",
                 sb.words_noted, sb.seed_loads);
        $display("%0d generations swept the grid with %0d diagonal direction draws",
                 sb.generations, sb.draws);
        if (sb.errors == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

    initial
    begin : watchdog
        #20_000_000;
        $display("simulation failed");
        $finish;
    end
endmodule

// ===== sim.f =====
rtl/fsgs_pkg.sv
rtl/fsgs_if.sv
rtl/fsgs_lfsr.sv
rtl/fsgs_engine.sv
rtl/falling_sand_grid_step.sv
tb/sv/tb.sv
